>>> rtl/core/crc16_word_frame_receiver_unit_assert.svh
// assertion macros for the top-level rtl file
`ifndef CRC16_WORD_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CRC16_WORD_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// plain property under reset
`define CRCWFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition in one cycle forces another in the next
`define CRCWFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CRCWFR_ASSERT(lbl, clk, rstn, prop, msg)
`define CRCWFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/core/crcwfr_pkg.sv
`default_nettype none

package crcwfr_pkg;

  localparam int MaxPayloadBytes = 128;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcTop     = 16'h8000;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [31:0] FrameMagic = 32'h444D4E54;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_CRC     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        payload_valid;
    logic [31:0] payload_word;
    logic [2:0]  payload_bytes;
    logic        frame_done;
    logic        frame_good;
    logic [15:0] frame_type;
    logic [7:0]  frame_length;
    logic        length_rejected;
  } result_t;

  // ccitt update for one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/crcwfr_crc.sv
`default_nettype none

// crc over the first nbytes_i bytes of data_i, byte 0 first
module crcwfr_crc (
  input  wire logic [15:0] crc_i,
  input  wire logic [31:0] data_i,
  input  wire logic [2:0]  nbytes_i,
  output logic [15:0]      crc_o
);
  import crcwfr_pkg::*;

  logic [15:0] c1, c2, c3, c4;

  assign c1 = crc_byte(crc_i, data_i[7:0]);
  assign c2 = crc_byte(c1, data_i[15:8]);
  assign c3 = crc_byte(c2, data_i[23:16]);
  assign c4 = crc_byte(c3, data_i[31:24]);

  always_comb begin
    case (nbytes_i)
      3'd1:    crc_o = c1;
      3'd2:    crc_o = c2;
      3'd3:    crc_o = c3;
      3'd4:    crc_o = c4;
      default: crc_o = crc_i;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/crcwfr_parser.sv
`default_nettype none

module crcwfr_parser #(
  parameter int MAX_PAYLOAD_BYTES = crcwfr_pkg::MaxPayloadBytes
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [31:0]   word_i,
  output crcwfr_pkg::result_t res_o
);
  import crcwfr_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int WORD_W = $clog2((MAX_PAYLOAD_BYTES + 3) / 4 + 1);

  phase_e              phase_q, phase_d;
  logic [15:0]         type_q, type_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [15:0]         exp_crc_q, exp_crc_d;
  logic [15:0]         crc_q, crc_d;
  logic [WORD_W-1:0]   words_q, words_d;
  logic [LEN_W-1:0]    bytes_q, bytes_d;

  logic [15:0]         crc_in;
  logic [31:0]         crc_data;
  logic [2:0]          crc_nbytes;
  logic [15:0]         crc_out;
  logic [2:0]          take;
  logic [LEN_W:0]      len_round;
  logic [LEN_W:0]      len_quarter;
  logic [WORD_W-1:0]   words_dec;
  logic [LEN_W+7:0]    len_ext;

  // header feeds type low byte, then length low and high bytes
  always_comb begin
    if (phase_q == PH_HEADER) begin
      crc_in     = CrcInit;
      crc_data   = {8'h00, word_i[15:8], word_i[7:0], word_i[23:16]};
      crc_nbytes = 3'd3;
    end else begin
      crc_in     = crc_q;
      crc_data   = word_i;
      crc_nbytes = take;
    end
  end

  crcwfr_crc u_crc (
    .crc_i    (crc_in),
    .data_i   (crc_data),
    .nbytes_i (crc_nbytes),
    .crc_o    (crc_out)
  );

  assign take        = (bytes_q < LEN_W'(4)) ? {1'b0, bytes_q[1:0]} : 3'd4;
  assign len_round   = {1'b0, len_q} + (LEN_W + 1)'(3);
  assign len_quarter = len_round >> 2;
  assign words_dec   = (words_q != '0) ? words_q - WORD_W'(1) : '0;

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_d     = len_q;
    exp_crc_d = exp_crc_q;
    crc_d     = crc_q;
    words_d   = words_q;
    bytes_d   = bytes_q;
    res_o     = '0;

    case (phase_q)
      PH_HUNT: begin
        if (word_i == FrameMagic) begin
          phase_d = PH_HEADER;
        end
      end
      PH_HEADER: begin
        type_d = word_i[31:16];
        if (word_i[15:0] > 16'(MAX_PAYLOAD_BYTES)) begin
          len_d                 = '0;
          res_o.length_rejected = 1'b1;
          phase_d               = PH_HUNT;
        end else begin
          len_d   = word_i[LEN_W-1:0];
          crc_d   = crc_out;
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        exp_crc_d = word_i[15:0];
        if (len_q == '0) begin
          // header-only frame ends on the crc word
          res_o.frame_done = 1'b1;
          res_o.frame_good = (crc_q == word_i[15:0]);
          phase_d          = PH_HUNT;
        end else begin
          words_d = len_quarter[WORD_W-1:0];
          bytes_d = len_q;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d               = crc_out;
        bytes_d             = bytes_q - LEN_W'(take);
        words_d             = words_dec;
        res_o.payload_valid = 1'b1;
        res_o.payload_word  = word_i;
        res_o.payload_bytes = take;
        if (words_dec == '0) begin
          res_o.frame_done = 1'b1;
          res_o.frame_good = (crc_out == exp_crc_q);
          bytes_d          = '0;
          phase_d          = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    res_o.frame_type   = type_d;
    len_ext            = {8'h00, len_d};
    res_o.frame_length = len_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      type_q    <= '0;
      len_q     <= '0;
      exp_crc_q <= '0;
      crc_q     <= CrcInit;
      words_q   <= '0;
      bytes_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      len_q     <= len_d;
      exp_crc_q <= exp_crc_d;
      crc_q     <= crc_d;
      words_q   <= words_d;
      bytes_q   <= bytes_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crc16_word_frame_receiver_unit.sv
// Framed link word receiver with CRC16-CCITT check (init 0xFFFF, poly 0x1021). Each input
// beat is one 32-bit link word and yields exactly one output beat, one beat per clock when
// both sides flow: the word is captured in an input register, parsed and run through a
// 32-bit parallel CRC update combinationally, and the result lands in an output register.
// Words are ignored until the magic word 0x444D4E54, then a header word (type high, byte
// length low) and a CRC word follow, then ceil(length/4) payload words. Payload words come
// out flagged in tuser with their valid byte count; tlast marks the word that ends a frame
// and carries the good/bad verdict, so frames marked bad must be dropped downstream.
// Lengths above MAX_PAYLOAD_BYTES raise length_rejected and hunting resumes.
`default_nettype none

`include "crc16_word_frame_receiver_unit_assert.svh"

module crc16_word_frame_receiver_unit #(
  parameter int MAX_PAYLOAD_BYTES = crcwfr_pkg::MaxPayloadBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // rx_word[31:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // payload_word[31:0], payload_bytes[34:32], frame_good[35], frame_type[51:36],
  // frame_length[59:52], length_rejected[60], zero[63:61]
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,  // frame_done
  output logic             m_axis_tuser   // payload_valid
);
  import crcwfr_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  result_t     res;
  logic        out_en;
  logic        in_beat;
  logic        step;

  assign out_en        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_en;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign step          = s1_valid_q && out_en;

  crcwfr_parser #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (s1_word_q),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_beat) begin
      s1_valid_d = 1'b1;
    end else if (out_en) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_word_q <= s_axis_tdata;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.length_rejected, out_q.frame_length, out_q.frame_type,
                          out_q.frame_good, out_q.payload_bytes, out_q.payload_word};
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tuser  = out_q.payload_valid;

  `CRCWFR_ASSERT(a_bytes_only_payload, clk_i, rst_ni,
    (m_axis_tvalid && out_q.payload_bytes != 3'd0) |-> out_q.payload_valid,
    "byte count on a non-payload beat")
  `CRCWFR_ASSERT(a_good_needs_done, clk_i, rst_ni,
    (m_axis_tvalid && out_q.frame_good) |-> out_q.frame_done,
    "crc verdict without frame end")
  `CRCWFR_ASSERT(a_reject_alone, clk_i, rst_ni,
    (m_axis_tvalid && out_q.length_rejected) |-> (!out_q.payload_valid && !out_q.frame_done),
    "rejected header mixed with frame data")
  `CRCWFR_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni,
    s1_valid_q && !out_en, s1_valid_q && $stable(s1_word_q),
    "input stage lost a stalled word")

endmodule

`default_nettype wire
